// ===== rtl/core/bss_pkg.sv =====
// Shared constants and types for the bounded set store.
// No dependencies; bss_ctrl, bounded_set_store and the bench import this package.
`default_nettype none

package bss_pkg;

  // Store geometry
  localparam int CAPACITY_ENTRIES = 32;
  localparam int KEY_WIDTH        = 32;

  // Keys arrive as 32 bits and compare as their low KEY_WIDTH bits
  localparam int KEY_IN_W = 32;
  localparam int STORE_W  = (KEY_WIDTH < KEY_IN_W) ? KEY_WIDTH : KEY_IN_W;

  localparam int ADDR_W  = (CAPACITY_ENTRIES > 1) ? $clog2(CAPACITY_ENTRIES) : 1;
  localparam int CNT_W   = $clog2(CAPACITY_ENTRIES + 1);
  localparam int COUNT_W = 6;

  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(CAPACITY_ENTRIES);

  // Operation codes
  localparam logic [1:0] OP_INSERT   = 2'd0;
  localparam logic [1:0] OP_REMOVE   = 2'd1;
  localparam logic [1:0] OP_CONTAINS = 2'd2;

  // Entry memory access for one cycle
  typedef struct packed {
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [STORE_W-1:0] wr_data;
  } ram_cmd_t;

  // One result item
  typedef struct packed {
    logic               found;
    logic [COUNT_W-1:0] count;
    logic               full_rejected;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/bss_if.sv =====
// Request and result channel interfaces of the bounded set store.
// Valid/ready handshake; fixed payload widths, no package needed.
`default_nettype none

interface bss_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic signed [31:0] key;

  modport source (output valid, output operation, output key, input ready);
  modport sink   (input valid, input operation, input key, output ready);
endinterface

interface bss_rsp_if;
  logic       valid;
  logic       ready;
  logic       found;
  logic [5:0] count;
  logic       full_rejected;

  modport source (output valid, output found, output count, output full_rejected,
                  input ready);
  modport sink   (input valid, input found, input count, input full_rejected,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bss_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// Standalone; widths come from its parameters.
`default_nettype none

module bss_ram #(
  parameter int DEPTH  = 32,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output      logic [WIDTH-1:0]  rd_data,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/bss_ctrl.sv =====
// Sequencer of the bounded set store: scans the entry memory, then
// inserts, swap-removes or just reports. Uses bss_pkg and bss_req_if.
`default_nettype none

module bss_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst,
  bss_req_if.sink                        req,
  output      bss_pkg::ram_cmd_t         ram_cmd,
  input  wire logic [bss_pkg::STORE_W-1:0] rd_data,
  output      logic                      res_valid,
  input  wire logic                      res_ready,
  output      bss_pkg::result_t          res
);
  import bss_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_ACT  = 3'd2;
  localparam logic [2:0] S_MOVE = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]         state;
  logic [1:0]         op;
  logic [STORE_W-1:0] key;
  logic [CNT_W-1:0]   idx;
  logic               cmp_vld;
  logic [CNT_W-1:0]   cmp_idx;
  logic [ADDR_W-1:0]  slot;
  logic               found;
  logic               rejected;
  logic [CNT_W-1:0]   cnt;

  logic               issue;
  logic               hit;
  logic [CNT_W-1:0]   last;
  logic [CNT_W+COUNT_W-1:0] cnt_ext;

  assign req.ready = (state == S_IDLE);
  assign issue     = (state == S_SCAN) && (idx < cnt);
  assign hit       = cmp_vld && (rd_data == key);
  assign last      = cnt - CNT_ONE;

  always_comb begin
    ram_cmd         = '0;
    ram_cmd.rd_addr = idx[ADDR_W-1:0];
    ram_cmd.wr_data = key;
    case (state)
      S_SCAN: begin
        ram_cmd.rd_en = issue;
      end
      S_ACT: begin
        if (op == OP_REMOVE && found && slot != last[ADDR_W-1:0]) begin
          ram_cmd.rd_en   = 1'b1;
          ram_cmd.rd_addr = last[ADDR_W-1:0];
        end
        if (op == OP_INSERT && !found && cnt < CNT_CAP) begin
          ram_cmd.wr_en   = 1'b1;
          ram_cmd.wr_addr = cnt[ADDR_W-1:0];
        end
      end
      S_MOVE: begin
        // last entry fills the hole
        ram_cmd.wr_en   = 1'b1;
        ram_cmd.wr_addr = slot;
        ram_cmd.wr_data = rd_data;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cnt     <= '0;
      cmp_vld <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            op       <= req.operation;
            key      <= req.key[STORE_W-1:0];
            idx      <= '0;
            cmp_vld  <= 1'b0;
            found    <= 1'b0;
            rejected <= 1'b0;
            state    <= (cnt == '0) ? S_ACT : S_SCAN;
          end
        end
        S_SCAN: begin
          cmp_vld <= issue;
          cmp_idx <= idx;
          if (issue) begin
            idx <= idx + CNT_ONE;
          end
          if (hit) begin
            found <= 1'b1;
            slot  <= cmp_idx[ADDR_W-1:0];
            state <= S_ACT;
          end else if (cmp_vld && (cmp_idx + CNT_ONE) == cnt) begin
            state <= S_ACT;
          end
        end
        S_ACT: begin
          state <= S_DONE;
          case (op)
            OP_INSERT: begin
              if (!found) begin
                if (cnt < CNT_CAP) begin
                  cnt <= cnt + CNT_ONE;
                end else begin
                  rejected <= 1'b1;
                end
              end
            end
            OP_REMOVE: begin
              if (found) begin
                if (slot == last[ADDR_W-1:0]) begin
                  cnt <= last;
                end else begin
                  state <= S_MOVE;
                end
              end
            end
            default: begin
            end
          endcase
        end
        S_MOVE: begin
          cnt   <= last;
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign cnt_ext           = {{COUNT_W{1'b0}}, cnt};
  assign res_valid         = (state == S_DONE);
  assign res.found         = found;
  assign res.count         = cnt_ext[COUNT_W-1:0];
  assign res.full_rejected = rejected;

endmodule

`default_nettype wire

// ===== rtl/core/bounded_set_store.sv =====
// Bounded set store: unordered key array with swap-on-remove and a count.
// A request is taken only in the idle state; the sequencer then scans the entries, acts,
// and for a remove that moves the last entry also moves it, then holds the result until
// the output register takes it, and only then takes the next request.
// Throughput is set by the linear scan of the entry RAM, one entry per cycle.
// Reset (rst, synchronous, active high) empties the store; entries need no clear.
// Depends on bss_pkg, bss_if, bss_ram and bss_ctrl.
`default_nettype none

module bounded_set_store (
  input  wire logic clk,
  input  wire logic rst,
  bss_req_if.sink   req,
  bss_rsp_if.source rsp
);
  import bss_pkg::*;

  ram_cmd_t           ram_cmd;
  logic [STORE_W-1:0] rd_data;
  logic               res_valid;
  logic               res_ready;
  result_t            res;

  // Output register
  logic               out_vld;
  result_t            out_data;

  // Entry storage: keys live only in this RAM
  bss_ram #(
    .DEPTH (CAPACITY_ENTRIES),
    .WIDTH (STORE_W),
    .ADDR_W(ADDR_W)
  ) u_ram (
    .clk    (clk),
    .rd_en  (ram_cmd.rd_en),
    .rd_addr(ram_cmd.rd_addr),
    .rd_data(rd_data),
    .wr_en  (ram_cmd.wr_en),
    .wr_addr(ram_cmd.wr_addr),
    .wr_data(ram_cmd.wr_data)
  );

  // Scan and update sequencer
  bss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .ram_cmd  (ram_cmd),
    .rd_data  (rd_data),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  // Load a finished item when the register is empty or drains this cycle;
  // hold it otherwise so the sequencer stalls in its done state.
  assign res_ready = !out_vld || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (res_ready) begin
      out_vld <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data <= res;
    end
  end

  assign rsp.valid         = out_vld;
  assign rsp.found         = out_data.found;
  assign rsp.count         = out_data.count;
  assign rsp.full_rejected = out_data.full_rejected;

  // A rejected insert never reports the key as present
  a_reject_not_found: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.found && rsp.full_rejected))
    else $error("full_rejected raised together with found");

  // One request at a time: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request accepted while another is in flight");

  // A result handed over by the sequencer shows up at the output
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_ready) |=> rsp.valid)
    else $error("finished item lost before the output register");

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking testbench for bounded_set_store: directed edge keys, fill/drain
// rounds, random traffic and a long result stall. Depends on bss_pkg, bss_if and bounded_set_store.
// The bench predicts every result from its own copy of the set contents.

module tb;
  import bss_pkg::*;

  // Unused operation code: the block answers it like a lookup
  localparam logic [1:0] OP_RESERVED = 2'd3;

  localparam logic [31:0] KEY_MIN  = 32'h8000_0000;
  localparam logic [31:0] KEY_MAX  = 32'h7FFF_FFFF;
  localparam logic [31:0] KEY_ONES = 32'hFFFF_FFFF;

  localparam int IDLE_PCT       = 36;
  localparam int HOLD_CYCLES    = 300;
  localparam int POOL_SIZE      = 40;
  localparam int MAX_PRINTS     = 25;
  localparam int TIMEOUT_CYCLES = 500000;

  logic clk;
  logic rst;

  bss_req_if req_ch ();
  bss_rsp_if rsp_ch ();

  bounded_set_store dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch.sink),
    .rsp (rsp_ch.source)
  );

  // Predicted set contents, updated as each request is accepted
  logic [STORE_W-1:0] set_keys [CAPACITY_ENTRIES];
  int                 set_count;

  // Predicted results, oldest first
  result_t expected_results [$];

  // Keys drawn from a small pool so lookups and removes hit stored entries
  logic [31:0] key_pool [$];

  // Side controls, written with nonblocking assignments at clock edges
  logic idle_on;
  logic rsp_hold;
  event hold_start;

  int mismatches;
  int requests_sent;
  int results_checked;
  int refusals_predicted;
  int peak_count;

  // Clock: period of 10 time units
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Give up if the run hangs
  initial begin
    #(TIMEOUT_CYCLES * 10);
    $display("tb NOT OK");
    $finish;
  end

  // Apply one request to the predicted set and return the result it causes.
  function automatic result_t apply_request(input logic [1:0] op,
                                            input logic [STORE_W-1:0] key);
    result_t r;
    int      slot;
    slot = set_count;
    for (int i = 0; i < set_count; i++) begin
      if (slot == set_count && set_keys[i] == key) slot = i;
    end
    r.found         = (slot < set_count);
    r.full_rejected = 1'b0;
    case (op)
      OP_INSERT: begin
        if (!r.found) begin
          if (set_count < CAPACITY_ENTRIES) begin
            set_keys[set_count] = key;
            set_count++;
          end else begin
            r.full_rejected = 1'b1;
          end
        end
      end
      OP_REMOVE: begin
        // Move the last stored key into the freed slot
        if (r.found) begin
          set_count--;
          set_keys[slot] = set_keys[set_count];
        end
      end
      default: begin
        // Lookup and the reserved code leave the set unchanged
      end
    endcase
    r.count = COUNT_W'(set_count);
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < MAX_PRINTS) $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // Offer one item, wait for the handshake, then record its predicted result.
  // Leave valid high on return so back-to-back items need no extra edge.
  task automatic send_item(input logic [1:0] op, input logic [31:0] key);
    result_t prediction;
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.operation <= op;
    req_ch.key       <= key;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    prediction = apply_request(op, key[STORE_W-1:0]);
    expected_results.push_back(prediction);
    requests_sent++;
    if (prediction.full_rejected) refusals_predicted++;
    if (set_count > peak_count) peak_count = set_count;
  endtask

  // Compare one accepted result with the oldest prediction.
  task automatic check_result();
    result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("result with no request pending");
    end else begin
      want = expected_results.pop_front();
      if (rsp_ch.found !== want.found)
        report_mismatch($sformatf("found %b, want %b", rsp_ch.found, want.found));
      if (rsp_ch.count !== want.count)
        report_mismatch($sformatf("count %0d, want %0d", rsp_ch.count, want.count));
      if (rsp_ch.full_rejected !== want.full_rejected)
        report_mismatch($sformatf("full_rejected %b, want %b",
                                  rsp_ch.full_rejected, want.full_rejected));
      results_checked++;
    end
  endtask

  // Result side: sample at each edge, then pick ready for the next one.
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready) check_result();
      if (rsp_hold)     rsp_ch.ready <= 1'b0;
      else if (idle_on) rsp_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
      else              rsp_ch.ready <= 1'b1;
    end
  end

  // Long result stall, counted here so the sender keeps offering items and
  // the block fills up and stops taking requests.
  initial begin
    rsp_hold <= 1'b0;
    forever begin
      @(hold_start);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      rsp_hold <= 1'b0;
    end
  end

  task automatic refill_pool();
    key_pool.delete();
    for (int i = 0; i < POOL_SIZE; i++) key_pool.push_back($urandom());
    // Mix in the extreme keys now and then
    if ($urandom_range(1)) key_pool[0] = KEY_MIN;
    if ($urandom_range(1)) key_pool[1] = KEY_MAX;
    if ($urandom_range(1)) key_pool[2] = KEY_ONES;
    if ($urandom_range(1)) key_pool[3] = '0;
  endtask

  // One random item: the percentages bias the mix toward growth or shrinkage.
  task automatic send_random(input int insert_pct, input int remove_pct);
    logic [1:0]  op;
    logic [31:0] key;
    int          pick;
    pick = $urandom_range(99);
    if (pick < insert_pct)                   op = OP_INSERT;
    else if (pick < insert_pct + remove_pct) op = OP_REMOVE;
    else if ($urandom_range(4) == 0)         op = OP_RESERVED;
    else                                     op = OP_CONTAINS;
    // Hold mostly to pool keys; throw in a stray key for noise
    if ($urandom_range(9) == 0) key = $urandom();
    else                        key = key_pool[$urandom_range(POOL_SIZE - 1)];
    send_item(op, key);
  endtask

  // Extreme keys, every operation, and each corner: lookup and remove on an
  // empty store, duplicate insert, removal that swaps the last entry in,
  // removal of the last entry, removal of an absent key, reserved code.
  task automatic test_edge_keys();
    send_item(OP_CONTAINS, '0);
    send_item(OP_REMOVE,   32'd5);
    send_item(OP_INSERT,   KEY_MIN);
    send_item(OP_INSERT,   KEY_MAX);
    send_item(OP_INSERT,   '0);
    send_item(OP_INSERT,   KEY_ONES);
    send_item(OP_INSERT,   KEY_MAX);
    send_item(OP_CONTAINS, KEY_MIN);
    send_item(OP_CONTAINS, 32'd1);
    send_item(OP_RESERVED, KEY_ONES);
    send_item(OP_RESERVED, 32'd12345);
    send_item(OP_REMOVE,   KEY_MIN);
    send_item(OP_CONTAINS, KEY_ONES);
    send_item(OP_REMOVE,   32'd77);
    send_item(OP_REMOVE,   KEY_ONES);
    send_item(OP_REMOVE,   '0);
    send_item(OP_REMOVE,   KEY_MAX);
    send_item(OP_REMOVE,   KEY_MAX);
    send_item(OP_INSERT,   32'h5555_5555);
    send_item(OP_INSERT,   32'hAAAA_AAAA);
    send_item(OP_REMOVE,   32'h5555_5555);
    send_item(OP_CONTAINS, 32'hAAAA_AAAA);
    send_item(OP_REMOVE,   32'hAAAA_AAAA);
  endtask

  // Fill the store to capacity, push against the full store, then drain it
  // in random order. The middle round runs with no idling on either side.
  task automatic test_fill_and_drain();
    for (int round = 0; round < 3; round++) begin
      idle_on <= (round != 1);
      while (set_count < CAPACITY_ENTRIES) send_item(OP_INSERT, $urandom());
      repeat (4) send_item(OP_INSERT, $urandom());
      send_item(OP_INSERT,   set_keys[$urandom_range(set_count - 1)]);
      send_item(OP_CONTAINS, set_keys[$urandom_range(set_count - 1)]);
      send_item(OP_RESERVED, set_keys[$urandom_range(set_count - 1)]);
      while (set_count > 0) begin
        if ($urandom_range(9) == 0) send_item(OP_REMOVE, $urandom());
        else send_item(OP_REMOVE, set_keys[$urandom_range(set_count - 1)]);
      end
    end
    idle_on <= 1'b1;
  endtask

  // Phases of random traffic: grow, shrink and balanced, each on a fresh pool.
  task automatic test_random_traffic();
    for (int phase = 0; phase < 7; phase++) begin
      refill_pool();
      repeat (100) begin
        case (phase % 3)
          0:       send_random(60, 15);
          1:       send_random(15, 55);
          default: send_random(35, 30);
        endcase
      end
    end
  endtask

  // Stall the result side for a long stretch while requests keep coming.
  task automatic test_result_backpressure();
    refill_pool();
    -> hold_start;
    repeat (80) send_random(45, 25);
  endtask

  initial begin
    mismatches         = 0;
    requests_sent      = 0;
    results_checked    = 0;
    refusals_predicted = 0;
    peak_count         = 0;
    set_count          = 0;
    rst              <= 1'b1;
    idle_on          <= 1'b1;
    req_ch.valid     <= 1'b0;
    req_ch.operation <= OP_INSERT;
    req_ch.key       <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_edge_keys();
    test_fill_and_drain();
    test_random_traffic();
    test_result_backpressure();

    // Drop valid, collect every outstanding result, then watch for strays
    req_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (CAPACITY_ENTRIES + 16) @(posedge clk);

    $display("covered %0d requests, %0d results checked, %0d inserts refused when full",
             requests_sent, results_checked, refusals_predicted);
    $display("peak occupancy %0d of %0d entries, %0d mismatches",
             peak_count, CAPACITY_ENTRIES, mismatches);
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/bss_pkg.sv
rtl/core/bss_if.sv
rtl/core/bss_ram.sv
rtl/core/bss_ctrl.sv
rtl/core/bounded_set_store.sv
bench/tb.sv
